[hw/rtl/sss_pkg.sv]
`default_nettype none

package sss_pkg;

  // digits per bank
  localparam int unsigned NUM_DIGITS = 5;
  localparam int unsigned DIGIT_W    = 3;
  localparam int unsigned SEG_W      = 8;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned CODE_W     = 3;
  localparam int unsigned CFG_IDX_W  = 2;

  // data bits are presented on even counts below this
  localparam logic [COUNT_W-1:0] DATA_TICK_LIMIT = 8'd20;

  localparam logic [COUNT_W-1:0] TICKS_PER_DIGIT_RST = 8'd75;
  localparam logic [COUNT_W-1:0] LATCH_TICK_RST      = 8'd16;
  localparam logic [DIGIT_W-1:0] LAST_DIGIT_RST      = 3'd4;
  localparam logic [SEG_W-1:0]   METER_DIGIT0_RST    = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICKS_PER_DIGIT = 2'd0,
    CFG_LATCH_TICK      = 2'd1,
    CFG_LAST_DIGIT      = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    MODE_TICK  = 1'b0,
    MODE_WRITE = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    SEL_NONE  = 2'd0,
    SEL_DEC   = 2'd1,
    SEL_METER = 2'd2,
    SEL_SPARE = 2'd3
  } bank_sel_t;

  // strobe code of the decimal bank per digit
  function automatic logic [CODE_W-1:0] dec_code(input logic [DIGIT_W-1:0] digit);
    logic [CODE_W-1:0] code;
    unique case (digit)
      3'd0:    code = 3'd0;
      3'd1:    code = 3'd1;
      3'd2:    code = 3'd2;
      3'd3:    code = 3'd6;
      3'd4:    code = 3'd4;
      default: code = 3'd0;
    endcase
    return code;
  endfunction

  // strobe code of the meter bank per digit
  function automatic logic [CODE_W-1:0] meter_code(input logic [DIGIT_W-1:0] digit);
    logic [CODE_W-1:0] code;
    unique case (digit)
      3'd0:    code = 3'd1;
      3'd1:    code = 3'd2;
      3'd2:    code = 3'd6;
      3'd3:    code = 3'd5;
      3'd4:    code = 3'd3;
      default: code = 3'd0;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/seven_segment_scan_shifter_unit.sv]
`default_nettype none
// path: an accepted tick passes through the read stage and then the output register
// throughput: one transaction per cycle, ticks and writes alike, unless the result channel
//   stalls; the single read port of each segment memory is read once per tick
// reset: synchronous, active high; counters, held outputs and registers take their
//   defaults and both segment memories read as their default contents at once
module seven_segment_scan_shifter_unit (
  input  wire                          clk,
  input  wire                          rst,
  // item channel
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire                          mode,
  input  wire  [sss_pkg::SEG_W-1:0]    char_value,
  input  wire  [sss_pkg::DIGIT_W-1:0]  digit_position,
  input  wire  [1:0]                   display_select,
  // result channel
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic                         shift_clock,
  output logic                         latch_pulse,
  output logic                         data_dec,
  output logic                         data_meter,
  output logic [sss_pkg::CODE_W-1:0]   strobe_dec,
  output logic [sss_pkg::CODE_W-1:0]   strobe_meter,
  // configuration channel
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [sss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [sss_pkg::COUNT_W-1:0]  cfg_data
);
  import sss_pkg::*;

  // configuration registers
  logic [COUNT_W-1:0] ticks_per_digit;
  logic [COUNT_W-1:0] latch_tick;
  logic [DIGIT_W-1:0] last_digit;

  // scan counters, updated when a tick is accepted
  logic [COUNT_W-1:0] tick_count;
  logic [COUNT_W-1:0] tick_count_next;
  logic [DIGIT_W-1:0] digit_index;
  logic [DIGIT_W-1:0] digit_index_next;
  logic [COUNT_W-1:0] count_inc;
  logic [DIGIT_W-1:0] digit_inc;

  // segment memories with per-entry written flags
  logic [SEG_W-1:0] dec_mem   [NUM_DIGITS];
  logic [SEG_W-1:0] meter_mem [NUM_DIGITS];
  logic [NUM_DIGITS-1:0] dec_vld;
  logic [NUM_DIGITS-1:0] meter_vld;
  logic [SEG_W-1:0] dec_rd;
  logic [SEG_W-1:0] meter_rd;
  logic             dec_rd_vld;
  logic             meter_rd_vld;

  // read stage: tick waiting for its memory data
  logic               s1_valid;
  logic               s1_latch;
  logic               s1_data_en;
  logic [3:0]         s1_shift;
  logic [DIGIT_W-1:0] s1_digit;

  logic in_fire;
  logic tick_fire;
  logic wr_fire;
  logic wr_in_range;
  logic out_free;
  logic s1_adv;

  logic [SEG_W-1:0]  dec_byte;
  logic [SEG_W-1:0]  meter_byte;
  logic              data_dec_next;
  logic              data_meter_next;
  logic [CODE_W-1:0] strobe_dec_next;
  logic [CODE_W-1:0] strobe_meter_next;

  // handshakes: the output register frees the read stage, which frees the input
  assign cfg_ready   = 1'b1;
  assign out_free    = !out_valid || out_ready;
  assign s1_adv      = s1_valid && out_free;
  assign in_ready    = !s1_valid || out_free;
  assign in_fire     = in_valid && in_ready;
  assign tick_fire   = in_fire && (mode == MODE_TICK);
  assign wr_fire     = in_fire && (mode == MODE_WRITE);
  assign wr_in_range = ({1'b0, digit_position} < 4'(NUM_DIGITS));

  // configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_digit <= TICKS_PER_DIGIT_RST;
      latch_tick      <= LATCH_TICK_RST;
      last_digit      <= LAST_DIGIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TICKS_PER_DIGIT: ticks_per_digit <= cfg_data;
        CFG_LATCH_TICK:      latch_tick      <= cfg_data;
        CFG_LAST_DIGIT:      last_digit      <= cfg_data[DIGIT_W-1:0];
        default:             ;
      endcase
    end
  end

  // count first, then the period check, then the digit wrap
  always_comb begin
    count_inc        = tick_count + 8'd1;
    digit_inc        = digit_index + 3'd1;
    tick_count_next  = count_inc;
    digit_index_next = digit_index;
    if (count_inc == ticks_per_digit) begin
      tick_count_next  = '0;
      digit_index_next = digit_inc;
      if (digit_inc > last_digit || {1'b0, digit_inc} >= 4'(NUM_DIGITS)) begin
        digit_index_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= '0;
      digit_index <= '0;
    end else if (tick_fire) begin
      tick_count  <= tick_count_next;
      digit_index <= digit_index_next;
    end
  end

  // memory port: at most one write per write transaction, one read per tick; both come
  // from accepted transactions, so a read never meets a write of the same cycle
  always_ff @(posedge clk) begin
    if (wr_fire && wr_in_range) begin
      if (display_select == SEL_DEC) begin
        dec_mem[digit_position] <= char_value;
      end
      if (display_select == SEL_METER) begin
        meter_mem[digit_position] <= char_value;
      end
    end
    if (tick_fire) begin
      dec_rd   <= dec_mem[digit_index_next];
      meter_rd <= meter_mem[digit_index_next];
    end
  end

  // written flags stand in for the reset contents of the memories
  always_ff @(posedge clk) begin
    if (rst) begin
      dec_vld      <= '0;
      meter_vld    <= '0;
      dec_rd_vld   <= 1'b0;
      meter_rd_vld <= 1'b0;
    end else begin
      if (wr_fire && wr_in_range) begin
        if (display_select == SEL_DEC) begin
          dec_vld[digit_position] <= 1'b1;
        end
        if (display_select == SEL_METER) begin
          meter_vld[digit_position] <= 1'b1;
        end
      end
      if (tick_fire) begin
        dec_rd_vld   <= dec_vld[digit_index_next];
        meter_rd_vld <= meter_vld[digit_index_next];
      end
    end
  end

  // read stage bookkeeping, decided on the new count
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= tick_fire;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      s1_latch   <= (tick_count_next == latch_tick);
      s1_data_en <= (tick_count_next < DATA_TICK_LIMIT) && !tick_count_next[0];
      s1_shift   <= tick_count_next[4:1];
      s1_digit   <= digit_index_next;
    end
  end

  // unwritten entries read as their reset contents
  always_comb begin
    dec_byte   = dec_rd_vld ? dec_rd : '0;
    meter_byte = meter_rd;
    if (!meter_rd_vld) begin
      meter_byte = (s1_digit == '0) ? METER_DIGIT0_RST : '0;
    end

    // shift of 8 or 9 presents a zero
    data_dec_next   = data_dec;
    data_meter_next = data_meter;
    if (s1_data_en) begin
      data_dec_next   = !s1_shift[3] && dec_byte[s1_shift[2:0]];
      data_meter_next = !s1_shift[3] && meter_byte[s1_shift[2:0]];
    end

    strobe_dec_next   = strobe_dec;
    strobe_meter_next = strobe_meter;
    if (s1_latch) begin
      strobe_dec_next   = dec_code(s1_digit);
      strobe_meter_next = meter_code(s1_digit);
    end
  end

  // output register doubles as the held display state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      shift_clock  <= 1'b0;
      latch_pulse  <= 1'b0;
      data_dec     <= 1'b0;
      data_meter   <= 1'b0;
      strobe_dec   <= '0;
      strobe_meter <= '0;
    end else if (s1_adv) begin
      out_valid    <= 1'b1;
      shift_clock  <= !shift_clock;
      latch_pulse  <= s1_latch;
      data_dec     <= data_dec_next;
      data_meter   <= data_meter_next;
      strobe_dec   <= strobe_dec_next;
      strobe_meter <= strobe_meter_next;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/sss_checker.sv]
`default_nettype none
module sss_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          in_valid,
  input wire                          in_ready,
  input wire                          mode,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire                          shift_clock,
  input wire                          latch_pulse,
  input wire                          data_dec,
  input wire                          data_meter,
  input wire  [sss_pkg::CODE_W-1:0]   strobe_dec,
  input wire  [sss_pkg::CODE_W-1:0]   strobe_meter
);
  import sss_pkg::*;

  logic              tick_in;
  logic              res_out;
  logic [1:0]        pending;
  logic              last_clock;
  logic [CODE_W-1:0] last_strobe_dec;

  assign tick_in = in_valid && in_ready && (mode == MODE_TICK);
  assign res_out = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending         <= '0;
      last_clock      <= 1'b0;
      last_strobe_dec <= '0;
    end else begin
      pending <= pending + {1'b0, tick_in} - {1'b0, res_out};
      if (res_out) begin
        last_clock      <= shift_clock;
        last_strobe_dec <= strobe_dec;
      end
    end
  end

  // a result only for a tick still owed
  a_result_owed: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("result shown with no tick outstanding");

  // at most two ticks in flight
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("too many ticks in flight");

  // shift clock alternates from one result to the next
  a_clock_toggles: assert property (@(posedge clk) disable iff (rst)
    res_out |-> shift_clock != last_clock)
    else $error("shift clock did not toggle");

  // decimal strobe code changes only with a latch pulse
  a_strobe_held: assert property (@(posedge clk) disable iff (rst)
    (res_out && !latch_pulse) |-> strobe_dec == last_strobe_dec)
    else $error("strobe changed without latch");

  // a stalled result stays valid and holds its clock, data bits and meter strobe
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(shift_clock)
      && $stable(data_dec) && $stable(data_meter) && $stable(strobe_meter)))
    else $error("stalled result changed");

endmodule

bind seven_segment_scan_shifter_unit sss_checker u_sss_checker (.*);
`default_nettype wire

[verif/seven_segment_scan_shifter_unit_tb.sv]
module seven_segment_scan_shifter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sss_pkg::*;

  // cycles to let pass once nothing is owed, covers a write still in flight
  localparam int unsigned SETTLE_CYCLES  = 6;
  // cycles with no transaction on any channel before the run is abandoned
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  // strobe codes by digit, digit 0 in the low three bits
  localparam logic [3*NUM_DIGITS-1:0] DEC_STROBES   = {3'd4, 3'd6, 3'd2, 3'd1, 3'd0};
  localparam logic [3*NUM_DIGITS-1:0] METER_STROBES = {3'd3, 3'd5, 3'd6, 3'd2, 3'd1};

  typedef struct packed {
    mode_t             mode;
    logic [SEG_W-1:0]  value;
    logic [DIGIT_W-1:0] pos;
    bank_sel_t         sel;
  } scan_item_t;

  typedef struct packed {
    cfg_reg_t           idx;
    logic [COUNT_W-1:0] data;
  } reg_write_t;

  typedef struct packed {
    logic              sclk;
    logic              latch;
    logic              dbit;
    logic              mbit;
    logic [CODE_W-1:0] dstrobe;
    logic [CODE_W-1:0] mstrobe;
  } scan_out_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // item channel
  logic               in_valid       = 1'b0;
  logic               in_ready;
  logic               mode           = 1'b0;
  logic [SEG_W-1:0]   char_value     = '0;
  logic [DIGIT_W-1:0] digit_position = '0;
  logic [1:0]         display_select = '0;

  // result channel
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              shift_clock;
  logic              latch_pulse;
  logic              data_dec;
  logic              data_meter;
  logic [CODE_W-1:0] strobe_dec;
  logic [CODE_W-1:0] strobe_meter;

  // configuration channel
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COUNT_W-1:0]   cfg_data  = '0;

  // stimulus and expectation stores
  scan_item_t pending_items[$];
  reg_write_t pending_reg_writes[$];
  scan_out_t  due_outputs[$];

  // when set neither side idles nor stalls
  logic        no_gaps = 1'b0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  // predictor copy of the registers
  logic [COUNT_W-1:0] p_period     = TICKS_PER_DIGIT_RST;
  logic [COUNT_W-1:0] p_latch_at   = LATCH_TICK_RST;
  logic [DIGIT_W-1:0] p_last_digit = LAST_DIGIT_RST;

  // predictor copy of the scanner state
  logic [COUNT_W-1:0] p_count   = '0;
  logic [DIGIT_W-1:0] p_digit   = '0;
  logic [SEG_W-1:0]   p_dec_segs   [NUM_DIGITS];
  logic [SEG_W-1:0]   p_meter_segs [NUM_DIGITS];
  logic               p_sclk    = 1'b0;
  logic               p_dbit    = 1'b0;
  logic               p_mbit    = 1'b0;
  logic [CODE_W-1:0]  p_dstrobe = '0;
  logic [CODE_W-1:0]  p_mstrobe = '0;

  seven_segment_scan_shifter_unit uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // one accepted transaction through the predictor; ticks leave an expected result
  task automatic predict_scan_step(input logic md, input logic [SEG_W-1:0] val,
                                   input logic [DIGIT_W-1:0] pos, input logic [1:0] sel);
    scan_out_t        want;
    logic [SEG_W-1:0] seg;
    logic [3:0]       seg_idx;
    if (md == MODE_WRITE) begin
      // out-of-range digits and the two unused selects leave the banks alone
      if (pos < NUM_DIGITS) begin
        if (sel == SEL_DEC) begin
          p_dec_segs[pos] = val;
        end else if (sel == SEL_METER) begin
          p_meter_segs[pos] = val;
        end
      end
    end else begin
      // count first; the 8-bit wrap matters when the period is zero
      p_count = p_count + 8'd1;
      want.latch = 1'b0;
      if (p_count == p_period) begin
        p_count = '0;
        p_digit = p_digit + 3'd1;
        // a last digit past the bank size behaves as the final digit
        if (p_digit > p_last_digit || p_digit >= NUM_DIGITS) begin
          p_digit = '0;
        end
      end
      // latch and data decisions look at the count after any clear
      if (p_count == p_latch_at) begin
        want.latch = 1'b1;
        p_dstrobe  = DEC_STROBES[p_digit*3 +: 3];
        p_mstrobe  = METER_STROBES[p_digit*3 +: 3];
      end
      if (p_count < DATA_TICK_LIMIT && !p_count[0]) begin
        seg_idx = p_count[4:1];
        // indices 8 and 9 run off the end of the byte and present zero
        seg    = p_dec_segs[p_digit];
        p_dbit = (seg_idx < 4'd8) ? seg[seg_idx[2:0]] : 1'b0;
        seg    = p_meter_segs[p_digit];
        p_mbit = (seg_idx < 4'd8) ? seg[seg_idx[2:0]] : 1'b0;
      end
      p_sclk = ~p_sclk;
      want.sclk    = p_sclk;
      want.dbit    = p_dbit;
      want.mbit    = p_mbit;
      want.dstrobe = p_dstrobe;
      want.mstrobe = p_mstrobe;
      due_outputs.push_back(want);
    end
  endtask

  function automatic void check_field(input string what, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // mostly ticks and well-formed writes, with some unconstrained writes the block may drop
  function automatic scan_item_t random_item();
    scan_item_t  it;
    int unsigned roll;
    roll     = $urandom_range(0, 99);
    it.value = SEG_W'($urandom_range(0, 255));
    it.pos   = DIGIT_W'($urandom_range(0, 7));
    it.sel   = bank_sel_t'($urandom_range(0, 3));
    if (roll < 70) begin
      it.mode = MODE_TICK;
    end else begin
      it.mode = MODE_WRITE;
      if (roll < 92) begin
        it.pos = DIGIT_W'($urandom_range(0, NUM_DIGITS - 1));
        it.sel = $urandom_range(0, 1) ? SEL_METER : SEL_DEC;
      end
    end
    return it;
  endfunction

  // wait until every channel is empty and nothing is owed, then let writes settle
  task automatic wait_quiet();
    do
      @(posedge clk);
    while (pending_items.size() != 0 || pending_reg_writes.size() != 0 || in_valid ||
           cfg_valid || due_outputs.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // new register setting on an idle block, then a batch of random transactions
  task automatic run_phase(input logic [COUNT_W-1:0] period,
                           input logic [COUNT_W-1:0] latch_at,
                           input logic [DIGIT_W-1:0] last, input int unsigned count);
    wait_quiet();
    pending_reg_writes.push_back(reg_write_t'{CFG_TICKS_PER_DIGIT, period});
    pending_reg_writes.push_back(reg_write_t'{CFG_LATCH_TICK, latch_at});
    pending_reg_writes.push_back(reg_write_t'{CFG_LAST_DIGIT, {5'd0, last}});
    wait_quiet();
    repeat (count) pending_items.push_back(random_item());
  endtask

  // item driver: predicts on acceptance, then offers the next pending transaction
  always @(posedge clk) begin : item_driver
    scan_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_scan_step(mode, char_value, digit_position, display_select);
      end
      // a transaction still waiting for ready keeps its valid and payload
      if (!(in_valid && !in_ready)) begin
        if (pending_items.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 25)) begin
          nxt = pending_items.pop_front();
          in_valid       <= 1'b1;
          mode           <= nxt.mode;
          char_value     <= nxt.value;
          digit_position <= nxt.pos;
          display_select <= nxt.sel;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // register driver: the predictor takes the new setting on the same edge
  always @(posedge clk) begin : reg_driver
    reg_write_t w;
    if (rst) begin
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TICKS_PER_DIGIT: p_period     = cfg_data;
          CFG_LATCH_TICK:      p_latch_at   = cfg_data;
          CFG_LAST_DIGIT:      p_last_digit = cfg_data[DIGIT_W-1:0];
          default: ;
        endcase
      end
      if (!(cfg_valid && !cfg_ready)) begin
        if (pending_reg_writes.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 25)) begin
          w = pending_reg_writes.pop_front();
          cfg_valid <= 1'b1;
          cfg_index <= w.idx;
          cfg_data  <= w.data;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: oldest expectation against each accepted result
  always @(posedge clk) begin : result_monitor
    scan_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_outputs.size() == 0) begin
        $display("%0t: unexpected result, expected none actual sclk %0b latch %0b",
                 $time, shift_clock, latch_pulse);
        mismatches++;
      end else begin
        want = due_outputs.pop_front();
        check_field("shift_clock",  want.sclk,    shift_clock);
        check_field("latch_pulse",  want.latch,   latch_pulse);
        check_field("data_dec",     want.dbit,    data_dec);
        check_field("data_meter",   want.mbit,    data_meter);
        check_field("strobe_dec",   want.dstrobe, strobe_dec);
        check_field("strobe_meter", want.mstrobe, strobe_meter);
      end
    end
    // receiver stalls about a quarter of the time
    out_ready <= no_gaps || ($urandom_range(0, 99) >= 25);
  end

  // abandon the run when no channel has moved for too long
  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int d;
    // banks as they come out of reset; meter digit 0 is all segments lit
    for (d = 0; d < NUM_DIGITS; d++) begin
      p_dec_segs[d]   = '0;
      p_meter_segs[d] = '0;
    end
    p_meter_segs[0] = METER_DIGIT0_RST;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed part under the reset setting: writes the block must drop
    pending_items.push_back(scan_item_t'{MODE_WRITE, 8'h12, 3'd0, SEL_NONE});
    pending_items.push_back(scan_item_t'{MODE_WRITE, 8'h34, 3'd1, SEL_SPARE});
    pending_items.push_back(scan_item_t'{MODE_WRITE, 8'hFF, 3'd7, SEL_DEC});
    pending_items.push_back(scan_item_t'{MODE_WRITE, 8'hFF, 3'd5, SEL_METER});
    // both ends of the decimal bank, the last meter digit and the extreme byte values
    pending_items.push_back(scan_item_t'{MODE_WRITE, 8'h81, 3'd0, SEL_DEC});
    pending_items.push_back(scan_item_t'{MODE_WRITE, 8'hFF, 3'd4, SEL_METER});
    pending_items.push_back(scan_item_t'{MODE_WRITE, 8'h00, 3'd4, SEL_DEC});
    // counts 1 to 18: data bits 1 to 7, the two past the byte, and the latch at 16
    repeat (18) pending_items.push_back(scan_item_t'{MODE_TICK, 8'hFF, 3'd7, SEL_SPARE});
    wait_quiet();
    repeat (120) pending_items.push_back(random_item());

    // shortest period with the latch on the clearing tick and a single digit
    run_phase(8'd20, 8'd0, 3'd0, 150);
    // longest period, a latch tick the count never reaches
    run_phase(8'd255, 8'd255, 3'd4, 400);
    // zero period only clears on the counter wrap; last digit beyond the bank
    run_phase(8'd0, 8'd19, 3'd7, 450);
    // long stretch with neither side idling, fast digit cycling
    no_gaps = 1'b1;
    run_phase(8'd20, 8'd19, 3'd4, 200);
    wait_quiet();
    no_gaps = 1'b0;
    run_phase(8'd21, 8'd20, 3'd5, 120);
    repeat (2) run_phase(COUNT_W'($urandom_range(20, 255)), COUNT_W'($urandom_range(0, 255)),
                         DIGIT_W'($urandom_range(0, 4)), 100);
    wait_quiet();

    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
